// ----- design/ibtb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibtb_pkg
// Shared types, field widths and codes of the interleaved branch target buffer.
// ----------------------------------------------------------------------------
package ibtb_pkg;

    // Default sizes
    localparam int BANKS_DEFAULT      = 4;
    localparam int INDEX_BITS_DEFAULT = 10;
    localparam int ADDR_BITS_DEFAULT  = 48;

    // Fixed field widths of the request and result beats
    localparam int FIELD_ADDR_W = 48;
    localparam int MASK_W       = 4;
    localparam int KIND_W       = 2;
    localparam int CTR_W        = 2;
    localparam int FUNC_W       = 2;

    // One bank slot of a table row: target, kind, counter
    localparam int SLOT_W = FIELD_ADDR_W + KIND_W + CTR_W;

    // Request kinds
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd2;

    // Branch kinds
    localparam logic [KIND_W-1:0] KIND_UNCOND = 2'd2;

    // Bimodal counter values
    localparam logic [CTR_W-1:0] CTR_MIN       = 2'd0;
    localparam logic [CTR_W-1:0] CTR_RESET     = 2'd1;
    localparam logic [CTR_W-1:0] CTR_TAKEN_MIN = 2'd2;
    localparam logic [CTR_W-1:0] CTR_MAX       = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [FIELD_ADDR_W-1:0] address;
        logic [FIELD_ADDR_W-1:0] target_address;
        logic [KIND_W-1:0]       branch_kind;
        logic                    outcome_taken;
    } ibtb_req_t;

    typedef struct packed {
        logic                    hit;
        logic [FIELD_ADDR_W-1:0] next_fetch_address;
        logic [MASK_W-1:0]       valid_mask;
    } ibtb_rsp_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } ibtb_state_t;

    // Sequencer status towards the datapath
    typedef struct packed {
        logic busy;
        logic accept;
        logic exec;
        logic clear;
    } ibtb_ctrl_t;

endpackage

// ----- design/ibtb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibtb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ibtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/ibtb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibtb_ctrl
// Sequencer: clearing sweep after reset, then an execute state for each accepted beat.
// ----------------------------------------------------------------------------
module ibtb_ctrl
    import ibtb_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output ibtb_ctrl_t            ctrl,
    output logic [INDEX_BITS-1:0] clear_index
);

    ibtb_state_t           state_reg, state_next;
    logic [INDEX_BITS-1:0] clear_cnt_reg, clear_cnt_next;

    // Status decode
    always_comb
    begin
        ctrl.busy   = (state_reg != ST_IDLE);
        ctrl.accept = start && (state_reg == ST_IDLE);
        ctrl.exec   = (state_reg == ST_EXEC);
        ctrl.clear  = (state_reg == ST_CLEAR);
    end

    assign clear_index = clear_cnt_reg;

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clear_cnt_next = clear_cnt_reg + 1'b1;
                if (&clear_cnt_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

endmodule

// ----- design/ibtb_row.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibtb_row
// Row datapath: address decode, query evaluation and row modify for add and
// predictor update.
// ----------------------------------------------------------------------------
module ibtb_row
    import ibtb_pkg::*;
#(
    parameter int BANKS      = BANKS_DEFAULT,
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
    parameter int ADDR_BITS  = ADDR_BITS_DEFAULT,
    localparam int BANK_BITS = $clog2(BANKS),
    localparam int AW        = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W,
    localparam int TAG_W     = AW - BANK_BITS,
    localparam int ROW_W     = TAG_W + BANKS * SLOT_W
) (
    input  ibtb_req_t             new_req,
    input  ibtb_req_t             cur_req,
    input  logic [ROW_W-1:0]      rdata,
    output logic [INDEX_BITS-1:0] rd_index,
    output logic [INDEX_BITS-1:0] wr_index,
    output logic                  row_we,
    output logic [ROW_W-1:0]      wr_row,
    output ibtb_rsp_t             rsp,
    output logic                  rsp_valid
);

    localparam int BANK_SEL_W = (BANK_BITS > 0) ? BANK_BITS : 1;
    localparam int TAGX_W     = (TAG_W > INDEX_BITS) ? TAG_W : INDEX_BITS;
    localparam int MASK_BANKS = (BANKS < MASK_W) ? BANKS : MASK_W;

    logic [AW-1:0]           new_addr, cur_addr, fall_addr;
    logic [TAG_W-1:0]        new_tag, cur_tag, stored_tag;
    logic [TAGX_W-1:0]       new_tag_x, cur_tag_x;
    logic [BANK_SEL_W-1:0]   cur_bank;
    logic [FIELD_ADDR_W-1:0] slot_target [BANKS];
    logic [KIND_W-1:0]       slot_kind   [BANKS];
    logic [CTR_W-1:0]        slot_ctr    [BANKS];
    logic [BANKS-1:0]        taken, first, slot_valid;
    logic [FIELD_ADDR_W-1:0] target_sel;
    logic                    any_taken, hit;

    // Address decode: bank, tag, index
    assign new_addr  = new_req.address[AW-1:0];
    assign cur_addr  = cur_req.address[AW-1:0];
    assign new_tag   = new_addr[AW-1:BANK_BITS];
    assign cur_tag   = cur_addr[AW-1:BANK_BITS];
    assign new_tag_x = TAGX_W'(new_tag);
    assign cur_tag_x = TAGX_W'(cur_tag);
    assign rd_index  = new_tag_x[INDEX_BITS-1:0];
    assign wr_index  = cur_tag_x[INDEX_BITS-1:0];

    if (BANK_BITS > 0)
    begin : g_bank_sel
        assign cur_bank = cur_addr[BANK_SEL_W-1:0];
    end
    else
    begin : g_bank_one
        assign cur_bank = '0;
    end

    // Row unpack
    assign stored_tag = rdata[TAG_W-1:0];
    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            slot_target[b] = rdata[TAG_W + b*SLOT_W +: FIELD_ADDR_W];
            slot_kind[b]   = rdata[TAG_W + b*SLOT_W + FIELD_ADDR_W +: KIND_W];
            slot_ctr[b]    = rdata[TAG_W + b*SLOT_W + FIELD_ADDR_W + KIND_W +: CTR_W];
        end
    end

    // Query: first taken bank wins, later slots drop out
    always_comb
    begin
        logic seen;
        seen       = 1'b0;
        target_sel = '0;
        for (int b = 0; b < BANKS; b++)
        begin
            taken[b]      = (slot_kind[b] == KIND_UNCOND) || (slot_ctr[b] >= CTR_TAKEN_MIN);
            first[b]      = taken[b] && !seen;
            slot_valid[b] = !seen;
            seen          = seen | taken[b];
            target_sel    = target_sel | ({FIELD_ADDR_W{first[b]}} & slot_target[b]);
        end
        any_taken = seen;
    end

    assign hit       = (stored_tag == cur_tag);
    assign fall_addr = cur_addr + AW'(BANKS);
    assign rsp_valid = (cur_req.func == FUNC_QUERY);

    always_comb
    begin
        rsp.hit                = hit;
        rsp.next_fetch_address = (hit && any_taken) ? target_sel
                                                    : FIELD_ADDR_W'(fall_addr);
        rsp.valid_mask         = '0;
        for (int i = 0; i < MASK_BANKS; i++)
        begin
            rsp.valid_mask[i] = hit ? slot_valid[i] : 1'b1;
        end
    end

    // Row modify for add and update
    always_comb
    begin
        logic [CTR_W-1:0] ctr;
        wr_row = rdata;
        row_we = 1'b0;
        ctr    = CTR_MIN;
        case (cur_req.func)
            FUNC_ADD:
            begin
                row_we              = 1'b1;
                wr_row[TAG_W-1:0]   = cur_tag;
                for (int b = 0; b < BANKS; b++)
                begin
                    if (BANK_SEL_W'(b) == cur_bank)
                    begin
                        wr_row[TAG_W + b*SLOT_W +: FIELD_ADDR_W] = cur_req.target_address;
                        wr_row[TAG_W + b*SLOT_W + FIELD_ADDR_W +: KIND_W] =
                            cur_req.branch_kind;
                    end
                end
            end
            FUNC_UPDATE:
            begin
                // empty (zero tag) entries are not trained
                row_we = (stored_tag != '0);
                for (int b = 0; b < BANKS; b++)
                begin
                    if (BANK_SEL_W'(b) == cur_bank)
                    begin
                        ctr = slot_ctr[b];
                        if (cur_req.outcome_taken)
                        begin
                            if (ctr != CTR_MAX)
                            begin
                                ctr = ctr + 1'b1;
                            end
                        end
                        else if (ctr != CTR_MIN)
                        begin
                            ctr = ctr - 1'b1;
                        end
                        wr_row[TAG_W + b*SLOT_W + FIELD_ADDR_W + KIND_W +: CTR_W] = ctr;
                    end
                end
            end
            default:
            begin
                row_we = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/interleaved_branch_target_buffer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interleaved_branch_target_buffer_unit
// Direct-mapped, bank-interleaved branch target buffer with 2-bit bimodal
// counters; one table row holds the tag and every bank's slot.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps the table to its empty state, one row a
// cycle, and holds busy high until every row is cleared. Then a beat is taken
// at a clock edge with start high and busy low, and busy stays high for the
// following cycle, so no new beat is taken while a beat executes:
// the cycle after acceptance reads the row from the single table RAM, and
// that same cycle modifies and writes it back or evaluates the query. A
// query's result appears with done high for exactly one cycle, the cycle in
// which busy drops again; it must be captured then. Add and update beats,
// and the unused request kind, give no result.
// ----------------------------------------------------------------------------
module interleaved_branch_target_buffer_unit
    import ibtb_pkg::*;
#(
    parameter int BANKS      = BANKS_DEFAULT,
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
    parameter int ADDR_BITS  = ADDR_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ibtb_req_t req,
    output logic      busy,
    output logic      done,
    output ibtb_rsp_t result
);

    localparam int BANK_BITS = $clog2(BANKS);
    localparam int AW        = (ADDR_BITS < FIELD_ADDR_W) ? ADDR_BITS : FIELD_ADDR_W;
    localparam int TAG_W     = AW - BANK_BITS;
    localparam int ROW_W     = TAG_W + BANKS * SLOT_W;
    localparam int DEPTH     = 1 << INDEX_BITS;

    ibtb_ctrl_t            ctrl_st;
    logic [INDEX_BITS-1:0] clear_index, rd_index, wr_index, ram_waddr;
    logic [ROW_W-1:0]      rdata, wr_row, reset_row, ram_wdata;
    logic                  row_we, rsp_valid, ram_we;
    ibtb_rsp_t             rsp;
    ibtb_req_t             req_reg;
    ibtb_rsp_t             result_reg;
    logic                  done_reg, done_next;

    // Sequencer
    ibtb_ctrl #(
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .ctrl        (ctrl_st),
        .clear_index (clear_index)
    );

    // Row datapath
    ibtb_row #(
        .BANKS      (BANKS),
        .INDEX_BITS (INDEX_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_row (
        .new_req   (req),
        .cur_req   (req_reg),
        .rdata     (rdata),
        .rd_index  (rd_index),
        .wr_index  (wr_index),
        .row_we    (row_we),
        .wr_row    (wr_row),
        .rsp       (rsp),
        .rsp_valid (rsp_valid)
    );

    // Empty row: zero tag, targets and kinds, counters weakly not taken
    always_comb
    begin
        reset_row = '0;
        for (int b = 0; b < BANKS; b++)
        begin
            reset_row[TAG_W + b*SLOT_W + FIELD_ADDR_W + KIND_W +: CTR_W] = CTR_RESET;
        end
    end

    // Table write port: clearing sweep or write-back
    assign ram_we    = ctrl_st.clear || (ctrl_st.exec && row_we);
    assign ram_waddr = ctrl_st.clear ? clear_index : wr_index;
    assign ram_wdata = ctrl_st.clear ? reset_row : wr_row;

    ibtb_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ctrl_st.accept),
        .raddr (rd_index),
        .rdata (rdata)
    );

    // Request beat register
    always_ff @(posedge clk)
    begin
        if (ctrl_st.accept)
        begin
            req_reg <= req;
        end
    end

    // Result register
    assign done_next = ctrl_st.exec && rsp_valid;

    always_ff @(posedge clk)
    begin
        if (done_next)
        begin
            result_reg <= rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    assign busy   = ctrl_st.busy;
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // A result only follows an execute cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(ctrl_st.exec))
        else $error("result strobe without a preceding execute cycle");

    // Execute cycle always follows an accepted beat
    a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_st.exec |-> $past(ctrl_st.accept))
        else $error("execute cycle without an accepted beat");

    // Table is written only by the sweep or a write-back
    a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (ctrl_st.clear || ctrl_st.exec))
        else $error("table write outside clearing or execute");

    // No beat is taken during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl_st.clear |=> !ctrl_st.exec)
        else $error("beat taken while the table was being cleared");
`endif

endmodule
